// File: sv/xmk_pkg.sv
// xmk_pkg: shared types and constants for the masked xoshiro keystream block.
// Holds queue sizing, register indexes, transaction structs and the mask table.
// No dependencies.
package xmk_pkg;

	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int QDATA_W = 64;
	localparam int CFG_IDX_W = 8;
	localparam int GEN_W = 64;
	localparam int WORD_W = 32;
	localparam int MASK_N = 32;
	localparam int MASK_GRP = 4;
	localparam int MASK_PER_GRP = MASK_N / MASK_GRP;
	localparam int ROT_L = 45;
	localparam int SHIFT_T = 17;

	localparam logic [CFG_IDX_W-1:0] REG_SEED0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SEED1 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SEED2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SEED3 = CFG_IDX_W'(3);

	typedef logic [WORD_W-1:0] word_t;

	// Bit 31 of the scrambled word selects entry 0.
	localparam word_t MASK_TABLE [0:MASK_N-1] = '{
		32'd2276344508, 32'd3868698040, 32'd2932233957, 32'd2481846377,
		32'd3315139130, 32'd1079154857, 32'd546696388,  32'd2042452297,
		32'd2280531969, 32'd3382719674, 32'd1837261007, 32'd352190692,
		32'd547788629,  32'd2406082427, 32'd1197860883, 32'd376254976,
		32'd3001847785, 32'd2516055065, 32'd2848289332, 32'd471417044,
		32'd120242309,  32'd3247271329, 32'd2552421204, 32'd2399516480,
		32'd3128873567, 32'd3305266045, 32'd976269268,  32'd2353587310,
		32'd3818595075, 32'd557748429,  32'd209807908,  32'd459673187
	};

	typedef struct packed {
		logic full;
		logic empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	typedef struct packed {
		word_t plain;
		word_t gen_lo;
	} work_t;

	typedef struct packed {
		word_t cipher;
		word_t keystream;
	} result_t;

endpackage

// File: sv/xmk_fifo.sv
// xmk_fifo: small show-ahead flip-flop queue for 64-bit transactions.
// Depends on xmk_pkg for depth, pointer widths and the status struct.
module xmk_fifo import xmk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [QDATA_W-1:0] wdata,
	input  logic               pop,
	output logic [QDATA_W-1:0] rdata,
	output q_stat_t            stat
);

	logic [QDATA_W-1:0] mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign stat.full = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;
	assign do_push = push & ~stat.full;
	assign do_pop = pop & ~stat.empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/xmk_front.sv
// xmk_front: generator state, seed register writes and input acceptance.
// Advances xoshiro256 once per accepted word and queues {plain, word one low}.
// Depends on xmk_pkg.
module xmk_front import xmk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GEN_W-1:0]     cfg_data,
	input  logic                 accept,
	input  word_t                plain_word,
	output work_t                work
);

	logic [GEN_W-1:0] w0_q, w1_q, w2_q, w3_q;
	logic [GEN_W-1:0] t, n0, n1, n2, n3, x3;
	logic cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid & cfg_ready;

	assign work.plain = plain_word;
	assign work.gen_lo = w1_q[WORD_W-1:0];

	always_comb begin
		t = w1_q << SHIFT_T;
		n2 = w2_q ^ w0_q;
		x3 = w3_q ^ w1_q;
		n1 = w1_q ^ n2;
		n0 = w0_q ^ x3;
		n2 = n2 ^ t;
		n3 = {x3[GEN_W-ROT_L-1:0], x3[GEN_W-1:GEN_W-ROT_L]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
			w2_q <= '0;
			w3_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_SEED0: w0_q <= cfg_data;
				REG_SEED1: w1_q <= cfg_data;
				REG_SEED2: w2_q <= cfg_data;
				REG_SEED3: w3_q <= cfg_data;
				default: ;
			endcase
		end else if (accept) begin
			w0_q <= n0;
			w1_q <= n1;
			w2_q <= n2;
			w3_q <= n3;
		end
	end

endmodule

// File: sv/xmk_back.sv
// xmk_back: scrambler and mask pipeline between the work queue and result queue.
// Issues only with room reserved in the result queue, so it never stalls.
// Depends on xmk_pkg.
module xmk_back import xmk_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  work_t   work,
	input  q_stat_t work_stat,
	input  q_stat_t res_stat,
	output logic    work_pop,
	output logic    res_push,
	output result_t res
);

	logic v_s1, v_s2, v_s3;
	word_t plain_s1, plain_s2, plain_s3;
	word_t scr_s1, scr_s2;
	word_t part_s3 [MASK_GRP];
	logic [QCNT_W:0] used;
	word_t x5, x5x, x9, ks;
	word_t part [MASK_GRP];

	assign used = {1'b0, res_stat.count} + (QCNT_W+1)'(v_s1) + (QCNT_W+1)'(v_s2)
		+ (QCNT_W+1)'(v_s3);
	assign work_pop = ~work_stat.empty & (used < (QCNT_W+1)'(QDEPTH));

	always_comb begin
		x5 = work.gen_lo + {work.gen_lo[WORD_W-3:0], 2'b00};
		x5x = x5 ^ {x5[WORD_W-8:0], 7'b0};
		x9 = scr_s1 + {scr_s1[WORD_W-4:0], 3'b000};
	end

	always_comb begin
		for (int g = 0; g < MASK_GRP; g++) begin
			part[g] = '0;
			for (int j = 0; j < MASK_PER_GRP; j++) begin
				if (scr_s2[WORD_W-1-(g*MASK_PER_GRP+j)]) begin
					part[g] = part[g] + MASK_TABLE[g*MASK_PER_GRP+j];
				end
			end
		end
	end

	always_comb begin
		ks = '0;
		for (int g = 0; g < MASK_GRP; g++) begin
			ks = ks + part_s3[g];
		end
	end

	assign res_push = v_s3;
	assign res.keystream = ks;
	assign res.cipher = plain_s3 ^ ks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= work_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		plain_s1 <= work.plain;
		scr_s1 <= x5x;
		plain_s2 <= plain_s1;
		scr_s2 <= x9;
		plain_s3 <= plain_s2;
		for (int g = 0; g < MASK_GRP; g++) begin
			part_s3[g] <= part[g];
		end
	end

endmodule

// File: sv/xoshiro_masked_keystream_xor_top.sv
// xoshiro_masked_keystream_xor_top: masked xoshiro256 keystream XOR cipher.
// Instantiates xmk_front, two xmk_fifo queues and xmk_back; uses xmk_pkg.
//
// Usage:
//   Seeds: write cfg_index 0..3 with a 64-bit value on cfg_data while
//   cfg_valid is high; cfg_ready is always high. Each write loads one state
//   word at once; other indexes are ignored. Write only while idle.
//   Input: a plain_word transaction is taken when push is high and full low.
//   Output: cipher_word and keystream_word of the oldest result are valid
//   while empty is low; pop high with empty low takes the transaction.
// Path: a result becomes visible after its input passes the work queue,
//   scramble, multiply by 9, masked partial sums and the result queue.
// Throughput: one word per cycle while the result side keeps popping; the
//   generator update is registered; the back end is a 3-stage pipeline.
// Stall: the back end issues only with a free result-queue slot reserved,
//   so a stalled receiver fills the result queue, then the 8-entry work
//   queue, after which full rises.
// Reset: arst_n low clears the generator state to zero and empties both
//   queues; with a zero state the keystream word is zero.
module xoshiro_masked_keystream_xor_top import xmk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GEN_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic [31:0]          plain_word,
	output logic                 empty,
	input  logic                 pop,
	output logic [31:0]          cipher_word,
	output logic [31:0]          keystream_word
);

	work_t work_in, work_out;
	result_t res_in, res_out;
	q_stat_t work_stat, res_stat;
	logic accept;
	logic work_pop;
	logic res_push;

	assign full = work_stat.full;
	assign empty = res_stat.empty;
	assign accept = push & ~work_stat.full;
	assign cipher_word = res_out.cipher;
	assign keystream_word = res_out.keystream;

	xmk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.plain_word (plain_word),
		.work       (work_in)
	);

	xmk_fifo u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (work_in),
		.pop    (work_pop),
		.rdata  (work_out),
		.stat   (work_stat)
	);

	xmk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.work      (work_out),
		.work_stat (work_stat),
		.res_stat  (res_stat),
		.work_pop  (work_pop),
		.res_push  (res_push),
		.res       (res_in)
	);

	xmk_fifo u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_out),
		.stat   (res_stat)
	);

endmodule
